// ===== rtl/tkrt_pkg.sv =====
// ============================================================================
// tkrt_pkg: shared types and constants of the top-K record tracker
// Record and item layouts, table depth, sort key codes, key selection.
// ============================================================================
`default_nettype none

package tkrt_pkg;

    localparam int TABLE_DEPTH = 16;                 // 2 .. 64
    localparam int RANK_W      = 6;                  // fixed width of the rank field
    localparam int RANK_CW     = $clog2(TABLE_DEPTH); // rank counter width

    localparam logic [2:0] KEY_LOGINS  = 3'd0;
    localparam logic [2:0] KEY_POSTS   = 3'd1;
    localparam logic [2:0] KEY_POSTWAR = 3'd2;
    localparam logic [2:0] KEY_CHATS   = 3'd3;
    localparam logic [2:0] KEY_LAST    = 3'd4;       // codes 5..7 also select this

    typedef struct packed {
        logic [31:0] tag;
        logic [30:0] logins;
        logic [30:0] posts;
        logic [30:0] postwar;
        logic [30:0] chats;
        logic [31:0] last;
    } rec_t;

    typedef struct packed {
        logic  occ;
        rec_t  rec;
    } slot_t;

    typedef struct packed {
        logic ins;      // insert the incoming record
        logic shift;    // read-out: move every entry one place toward the head
        logic clear;    // drop every entry
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] account_tag;
        logic [30:0] login_count;
        logic [30:0] post_count;
        logic [30:0] postwar_count;
        logic [30:0] chat_count;
        logic [31:0] last_login_time;
        logic        end_of_list;
    } in_item_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              present;
        logic [31:0]       out_tag;
        logic [30:0]       out_logins;
        logic [30:0]       out_posts;
        logic [30:0]       out_postwar;
        logic [30:0]       out_chats;
        logic [31:0]       out_last_login;
        logic              final_res;
    } out_item_t;

    function automatic logic [31:0] key_of(input rec_t r, input logic [2:0] sel);
        logic [31:0] k;
        begin
            case (sel)
                KEY_LOGINS:  k = {1'b0, r.logins};
                KEY_POSTS:   k = {1'b0, r.posts};
                KEY_POSTWAR: k = {1'b0, r.postwar};
                KEY_CHATS:   k = {1'b0, r.chats};
                default:     k = r.last;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/top_k_record_tracker.sv =====
// ============================================================================
// top_k_record_tracker: keeps the K records with the largest key
// Sorted chain of cells with insertion, read-out sequencer and output register.
// ============================================================================
// A record is taken every cycle while the block is collecting: all cells
// compare the incoming key at once and the chain opens a gap at the first
// cell whose key is smaller (ties stay ahead of the newcomer), pushing the
// tail down by one. On a full table a record enters only if its key is
// strictly greater than the tail's. An item with end_of_list is inserted
// the same way and then starts read-out: the chain shifts toward the head
// one place per cycle whenever the output register is free (paced by
// out_ready, which can stall it), and the head feeds the output register. No
// item is taken during read-out. Read-out stops before the first entry with
// a zero key, flags the last result with final_res and empties the table.
// If the head has a zero key or the table is empty, a single result with
// present 0 and all record fields zero is sent. sort_key is written with
// cfg_wr_en/cfg_wr_data; codes 5..7 select the last login time.
// ============================================================================
`default_nettype none

module top_k_record_tracker (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire  [2:0]            cfg_wr_data,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  tkrt_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  wire                   out_ready,
    output tkrt_pkg::out_item_t   out_item
);

    localparam int DEPTH = tkrt_pkg::TABLE_DEPTH;
    localparam int RCW   = tkrt_pkg::RANK_CW;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [RCW-1:0]          rank_reg, rank_next;
    logic                    out_valid_reg, out_valid_next;
    tkrt_pkg::out_item_t     out_item_reg, out_item_next;
    logic [2:0]              sort_key_reg;

    tkrt_pkg::rec_t          new_rec;
    logic [31:0]             new_key;
    tkrt_pkg::cell_ctrl_t    ctrl;

    tkrt_pkg::slot_t         slots    [DEPTH];
    logic [31:0]             keys     [DEPTH];
    logic                    ge       [DEPTH];
    logic                    ahead_ok [DEPTH+1];
    tkrt_pkg::slot_t         empty_slot;

    logic                    accept_in;
    logic                    out_free;
    logic                    head_hit;
    logic                    next_hit;

    // Incoming record and its key
    assign new_rec.tag     = in_item.account_tag;
    assign new_rec.logins  = in_item.login_count;
    assign new_rec.posts   = in_item.post_count;
    assign new_rec.postwar = in_item.postwar_count;
    assign new_rec.chats   = in_item.chat_count;
    assign new_rec.last    = in_item.last_login_time;
    assign new_key         = tkrt_pkg::key_of(new_rec, sort_key_reg);

    // Boundary neighbor: never occupied
    assign empty_slot.occ = 1'b0;
    assign empty_slot.rec = new_rec;

    assign ahead_ok[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            tkrt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sort_key   (sort_key_reg),
                .new_rec    (new_rec),
                .new_key    (new_key),
                .prev_slot  ((g == 0) ? empty_slot : slots[(g == 0) ? 0 : g-1]),
                .next_slot  ((g == DEPTH-1) ? empty_slot
                                            : slots[(g == DEPTH-1) ? g : g+1]),
                .before_in  (ahead_ok[g]),
                .before_out (ahead_ok[g+1]),
                .ge         (ge[g]),
                .slot       (slots[g]),
                .key        (keys[g])
            );
        end
    endgenerate

    assign in_ready  = (state_reg == ST_COLLECT);
    assign accept_in = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign head_hit  = slots[0].occ && (keys[0] != 32'd0);
    assign next_hit  = slots[1].occ && (keys[1] != 32'd0);

    always_comb
    begin
        state_next     = state_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        ctrl.ins       = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.clear     = 1'b0;

        // Full table with tail key >= new key: record is dropped
        if (accept_in && !ge[DEPTH-1])
        begin
            ctrl.ins = 1'b1;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept_in && in_item.end_of_list)
                begin
                    state_next = ST_DRAIN;
                    rank_next  = '0;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '0;
                    out_item_next.rank[RCW-1:0] = rank_reg;
                    if (!head_hit)
                    begin
                        // nothing qualified
                        out_item_next.final_res = 1'b1;
                        ctrl.clear = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        out_item_next.present        = 1'b1;
                        out_item_next.out_tag        = slots[0].rec.tag;
                        out_item_next.out_logins     = slots[0].rec.logins;
                        out_item_next.out_posts      = slots[0].rec.posts;
                        out_item_next.out_postwar    = slots[0].rec.postwar;
                        out_item_next.out_chats      = slots[0].rec.chats;
                        out_item_next.out_last_login = slots[0].rec.last;
                        out_item_next.final_res      = !next_hit;
                        if (!next_hit)
                        begin
                            ctrl.clear = 1'b1;
                            state_next = ST_COLLECT;
                        end
                        else
                        begin
                            ctrl.shift = 1'b1;
                            rank_next  = rank_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            sort_key_reg  <= tkrt_pkg::KEY_LOGINS;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
            if (cfg_wr_en)
            begin
                sort_key_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/tkrt_cell.sv =====
// ============================================================================
// tkrt_cell: one slot of the sorted record chain
// Holds one record; compares against the incoming key, then keeps, captures
// the new record, or takes its neighbor's record.
// ============================================================================
`default_nettype none

module tkrt_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  tkrt_pkg::cell_ctrl_t     ctrl,
    input  wire  [2:0]               sort_key,
    input  tkrt_pkg::rec_t           new_rec,
    input  wire  [31:0]              new_key,
    input  tkrt_pkg::slot_t          prev_slot,   // neighbor toward the head
    input  tkrt_pkg::slot_t          next_slot,   // neighbor toward the tail
    input  wire                      before_in,   // all cells ahead hold key >= new
    output logic                     before_out,
    output logic                     ge,
    output tkrt_pkg::slot_t          slot,
    output logic [31:0]              key
);

    logic            occ_reg;
    tkrt_pkg::rec_t  rec_reg;

    assign key        = tkrt_pkg::key_of(rec_reg, sort_key);
    assign ge         = occ_reg && (key >= new_key);
    assign before_out = before_in && ge;
    assign slot.occ   = occ_reg;
    assign slot.rec   = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            occ_reg <= 1'b0;
        end
        else if (ctrl.ins)
        begin
            if (before_in && !ge)
            begin
                occ_reg <= 1'b1;
            end
            else if (!before_in)
            begin
                occ_reg <= prev_slot.occ;
            end
        end
        else if (ctrl.shift)
        begin
            occ_reg <= next_slot.occ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins && !ctrl.clear)
        begin
            if (before_in && !ge)
            begin
                rec_reg <= new_rec;
            end
            else if (!before_in)
            begin
                rec_reg <= prev_slot.rec;
            end
        end
        else if (ctrl.shift && !ctrl.clear)
        begin
            rec_reg <= next_slot.rec;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top_k_record_tracker.sv =====
// ============================================================================
// tb_top_k_record_tracker: self-checking bench for the top-K record tracker
// Streams account records through the input handshake. For every accepted
// item, a cycle-free model of the ranked table is updated. Each ranked
// result is compared field by field with the oldest pending prediction.
// A short directed table runs first, then random runs under all sort-key
// codes and several flow-control modes, including a long output hold-off.
// ============================================================================

module tb_top_k_record_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;       // 12 ns period
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 20;      // read-out of a full table plus margin
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_ITEMS    = 384;     // runs overshoot, total lands near 480
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 40;

    // Codes 5..7 are not named in the package; they all fall back to last login.
    localparam logic [2:0] KEY_ALIAS_5 = 3'd5;
    localparam logic [2:0] KEY_ALIAS_6 = 3'd6;
    localparam logic [2:0] KEY_ALIAS_7 = 3'd7;

    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
    localparam logic [31:0] WIDE_MAX  = 32'hFFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    tkrt_pkg::in_item_t    in_item;
    logic                  out_valid;
    logic                  out_ready;
    tkrt_pkg::out_item_t   out_item;

    top_k_record_tracker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    // ------------------------------------------------------------------------
    // Ranked-table model: sorted records, fill level, current key select.
    // ------------------------------------------------------------------------
    tkrt_pkg::rec_t        top_rec [tkrt_pkg::TABLE_DEPTH];
    int                    top_held;
    logic [2:0]            rank_key;
    tkrt_pkg::out_item_t   ranked_q [$];        // ranked results still owed by the block

    // Flow control knobs, percent of cycles
    int          send_gap_pct;
    int          recv_stall_pct;
    bit          start_hold;          // asks the receiver for one long hold-off
    int          hold_left;

    int          fail_count;
    int          records_sent;
    int          readouts_seen;
    int          results_checked;
    int          cycle_count;

    // One line of the directed table
    typedef struct {
        bit                    wr_key;          // write sort_key (idle) before this item
        logic [2:0]            key;
        tkrt_pkg::in_item_t    item;
        bit                    typed;           // expected result typed in below
        tkrt_pkg::out_item_t   want;
    } directed_row_t;

    directed_row_t directed_rows [$];

    // Key the table is ranked by; codes above chats all mean last login
    function automatic logic [31:0] rank_value(input tkrt_pkg::rec_t r);
        case (rank_key)
            tkrt_pkg::KEY_LOGINS:  return {1'b0, r.logins};
            tkrt_pkg::KEY_POSTS:   return {1'b0, r.posts};
            tkrt_pkg::KEY_POSTWAR: return {1'b0, r.postwar};
            tkrt_pkg::KEY_CHATS:   return {1'b0, r.chats};
            default:               return r.last;
        endcase
    endfunction

    // Insert one record, and on end of list queue the whole read-out.
    // A typed expectation replaces the computed one, state is still advanced.
    task automatic track_record(input tkrt_pkg::in_item_t it, input bit typed,
                                input tkrt_pkg::out_item_t typed_res);
        tkrt_pkg::rec_t        r;
        logic [31:0]           k;
        int                    n;
        int                    pos;
        int                    emit;
        bit                    take;
        tkrt_pkg::out_item_t   res;
        r.tag     = it.account_tag;
        r.logins  = it.login_count;
        r.posts   = it.post_count;
        r.postwar = it.postwar_count;
        r.chats   = it.chat_count;
        r.last    = it.last_login_time;
        k    = rank_value(r);
        n    = top_held;
        take = 1'b1;
        // full table: only a strictly larger key pushes out the tail
        if (n >= tkrt_pkg::TABLE_DEPTH) begin
            if (!(k > rank_value(top_rec[tkrt_pkg::TABLE_DEPTH-1])))
                take = 1'b0;
            n = tkrt_pkg::TABLE_DEPTH - 1;
        end
        if (take) begin
            pos = 0;
            // ties stay ahead of the newcomer
            while (pos < n && rank_value(top_rec[pos]) >= k)
                pos++;
            for (int i = n; i > pos; i--)
                top_rec[i] = top_rec[i-1];
            top_rec[pos] = r;
            top_held = n + 1;
        end
        if (!it.end_of_list)
            return;
        readouts_seen++;
        emit = 0;
        while (emit < top_held && rank_value(top_rec[emit]) != 0)
            emit++;
        top_held = 0;
        if (typed) begin
            ranked_q.push_back(typed_res);
            return;
        end
        if (emit == 0) begin
            res           = '0;
            res.final_res = 1'b1;
            ranked_q.push_back(res);
            return;
        end
        for (int i = 0; i < emit; i++) begin
            res.rank           = i[tkrt_pkg::RANK_W-1:0];
            res.present        = 1'b1;
            res.out_tag        = top_rec[i].tag;
            res.out_logins     = top_rec[i].logins;
            res.out_posts      = top_rec[i].posts;
            res.out_postwar    = top_rec[i].postwar;
            res.out_chats      = top_rec[i].chats;
            res.out_last_login = top_rec[i].last;
            res.final_res      = (i == emit - 1);
            ranked_q.push_back(res);
        end
    endtask

    function automatic tkrt_pkg::in_item_t make_record(input logic [31:0] tag,
                                                       input logic [30:0] logins,
                                                       input logic [30:0] posts,
                                                       input logic [30:0] postwar,
                                                       input logic [30:0] chats,
                                                       input logic [31:0] last,
                                                       input logic eol);
        tkrt_pkg::in_item_t it;
        it.account_tag     = tag;
        it.login_count     = logins;
        it.post_count      = posts;
        it.postwar_count   = postwar;
        it.chat_count      = chats;
        it.last_login_time = last;
        it.end_of_list     = eol;
        return it;
    endfunction

    function automatic tkrt_pkg::out_item_t make_result(input logic present,
                                                        input logic [31:0] tag,
                                                        input logic [30:0] cnt,
                                                        input logic [31:0] last);
        tkrt_pkg::out_item_t res;
        res                = '0;
        res.present        = present;
        res.out_tag        = tag;
        res.out_logins     = cnt;
        res.out_posts      = cnt;
        res.out_postwar    = cnt;
        res.out_chats      = cnt;
        res.out_last_login = last;
        res.final_res      = 1'b1;
        return res;
    endfunction

    function automatic void add_row(input bit wr, input logic [2:0] key,
                                    input tkrt_pkg::in_item_t it,
                                    input bit typed, input tkrt_pkg::out_item_t want);
        directed_row_t row;
        row.wr_key = wr;
        row.key    = key;
        row.item   = it;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // Counts: often tiny values so that ties are common, some extremes, some full range
    function automatic logic [30:0] pick_count();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0:          return '0;
            1:          return COUNT_MAX;
            2, 3, 4, 5: return 31'($urandom_range(7));
            default:    return v[30:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_wide();
        case ($urandom_range(9))
            0:          return '0;
            1:          return WIDE_MAX;
            2, 3, 4, 5: return 32'($urandom_range(7));
            default:    return $urandom();
        endcase
    endfunction

    function automatic tkrt_pkg::in_item_t random_record(input logic eol);
        return make_record($urandom(), pick_count(), pick_count(), pick_count(),
                           pick_count(), pick_wide(), eol);
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    task automatic build_directed_rows();
        int fill_posts [16] = '{30, 12, 30, 7, 45, 12, 3, 60, 7, 22, 3, 45, 18, 9, 3, 50};
        // empty read-out straight after reset: zero key, nothing qualifies
        add_row(0, tkrt_pkg::KEY_LOGINS, make_record('0, '0, '0, '0, '0, '0, 1'b1),
                1, make_result(1'b0, '0, '0, '0));
        // every field at its top value, ranked alone
        add_row(0, tkrt_pkg::KEY_LOGINS,
                make_record(WIDE_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, WIDE_MAX, 1'b1),
                1, make_result(1'b1, WIDE_MAX, COUNT_MAX, WIDE_MAX));
        // out-of-range key code ranks by last login
        add_row(1, KEY_ALIAS_7, make_record('0, '0, '0, '0, '0, WIDE_MAX, 1'b1),
                1, make_result(1'b1, '0, '0, WIDE_MAX));
        // ranked by chats, with a tie, then the key flips to postwar mid-list:
        // no re-sort, and read-out stops at the first zero postwar entry
        add_row(1, tkrt_pkg::KEY_CHATS,   make_record(32'h201, 1, 1, 3, 5, 11, 1'b0), 0, '0);
        add_row(0, tkrt_pkg::KEY_CHATS,   make_record(32'h202, 2, 2, 0, 5, 12, 1'b0), 0, '0);
        add_row(0, tkrt_pkg::KEY_CHATS,   make_record(32'h203, 3, 3, 8, 9, 13, 1'b0), 0, '0);
        add_row(0, tkrt_pkg::KEY_CHATS,   make_record(32'h204, 4, 4, 2, 0, 14, 1'b0), 0, '0);
        add_row(1, tkrt_pkg::KEY_POSTWAR, make_record(32'h205, 5, 5, 4, 1, 15, 1'b1), 0, '0);
        // fill a full table by posts with repeats
        for (int i = 0; i < 16; i++)
            add_row(i == 0, tkrt_pkg::KEY_POSTS,
                    make_record(32'h300 + 32'(i), 31'(i), 31'(fill_posts[i]), 31'(i + 1),
                                31'(i + 2), 32'(1000 + i), 1'b0), 0, '0);
        // equal to the tail on a full table: dropped
        add_row(0, tkrt_pkg::KEY_POSTS, make_record(32'h3F0, 1, 3, 1, 1, 1, 1'b0), 0, '0);
        // one above the tail: replaces it, then read-out of all sixteen
        add_row(0, tkrt_pkg::KEY_POSTS, make_record(32'h3F1, 2, 4, 2, 2, 2, 1'b1), 0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Sender side: drive at the falling edge, see acceptance at the rising one
    // ------------------------------------------------------------------------
    task automatic offer_record(input tkrt_pkg::in_item_t it, input bit typed,
                                input tkrt_pkg::out_item_t typed_res);
        @(negedge clk);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        records_sent++;
        track_record(it, typed, typed_res);
    endtask

    // Stop offering, let every owed result drain, then change the key.
    // The table may still hold records: that is the mid-stream key change.
    task automatic settle_and_set_key(input logic [2:0] key);
        @(negedge clk);
        in_valid <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= key;
        rank_key     = key;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        tkrt_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (ranked_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, got rank %0d tag %0h",
                             $time, out_item.rank, out_item.out_tag);
            end
            else begin
                want = ranked_q.pop_front();
                results_checked++;
                check_field("rank",        32'(want.rank),        32'(out_item.rank));
                check_field("present",     32'(want.present),     32'(out_item.present));
                check_field("out_tag",     want.out_tag,          out_item.out_tag);
                check_field("out_logins",  32'(want.out_logins),  32'(out_item.out_logins));
                check_field("out_posts",   32'(want.out_posts),   32'(out_item.out_posts));
                check_field("out_postwar", 32'(want.out_postwar), 32'(out_item.out_postwar));
                check_field("out_chats",   32'(want.out_chats),   32'(out_item.out_chats));
                check_field("out_last_login", want.out_last_login, out_item.out_last_login);
                check_field("final_res",   32'(want.final_res),   32'(out_item.final_res));
            end
        end
    end

    // Run guard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results still owed", $time, ranked_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiver: random stalls per phase, plus one long hold-off on request
    initial begin : drive_out_ready
        out_ready <= 1'b0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (start_hold) begin
                start_hold = 1'b0;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [2:0] phase_keys [NUM_PHASES];
        int         phase_items;
        int         run_len;
        phase_keys = '{tkrt_pkg::KEY_LAST, tkrt_pkg::KEY_LOGINS, KEY_ALIAS_7,
                       tkrt_pkg::KEY_POSTS, tkrt_pkg::KEY_POSTWAR, tkrt_pkg::KEY_CHATS,
                       KEY_ALIAS_5, KEY_ALIAS_6};
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        in_valid       <= 1'b0;
        in_item        <= '0;
        send_gap_pct    = 0;
        recv_stall_pct  = 0;
        start_hold      = 1'b0;
        fail_count      = 0;
        records_sent    = 0;
        readouts_seen   = 0;
        results_checked = 0;
        cycle_count     = 0;
        top_held        = 0;
        rank_key        = tkrt_pkg::KEY_LOGINS;        // register reset value
        for (int i = 0; i < tkrt_pkg::TABLE_DEPTH; i++)
            top_rec[i] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, free-flowing handshakes
        build_directed_rows();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].wr_key)
                settle_and_set_key(directed_rows[i].key);
            offer_record(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // random part: runs of records closed by an end-of-list item;
        // long runs overflow the table, empty runs rank the end-of-list record alone
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_and_set_key(phase_keys[p]);
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
                default: begin send_gap_pct = 6; recv_stall_pct = 6; end
            endcase
            // long output back-pressure while the sender keeps pushing:
            // the block must fill up and hold off its input
            if (p == 0)
                start_hold = 1'b1;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
                run_len = ($urandom_range(3) == 0) ? $urandom_range(17, 40) : $urandom_range(15);
                repeat (run_len) begin
                    offer_record(random_record(1'b0), 1'b0, '0);
                    phase_items++;
                end
                offer_record(random_record(1'b1), 1'b0, '0);
                phase_items++;
            end
            // sometimes leave records in the table across the next key change
            if ($urandom_range(1) == 1)
                repeat ($urandom_range(1, 5))
                    offer_record(random_record(1'b0), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (ranked_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d records, %0d read-outs and %0d ranked results checked,",
                 records_sent, readouts_seen, results_checked);
        $display("across all eight sort-key codes, ties, full-table drops and output hold-off.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== top_k_record_tracker.f =====
rtl/tkrt_pkg.sv
rtl/tkrt_cell.sv
rtl/top_k_record_tracker.sv
tb/tb_top_k_record_tracker.sv
